@@ rtl/nhe_pkg.sv @@
// shared constants, codes and types for the nibble huffman encoder / packer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package nhe_pkg;

    // field widths
    localparam int FUNC_W       = 2;
    localparam int SYM_W        = 4;
    localparam int LEN_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int MAX_CODE_LEN = 15;
    localparam int CODE_W       = MAX_CODE_LEN;
    localparam int TABLE_DEPTH  = 1 << SYM_W;

    // stream payload widths
    localparam int S_FIELDS_W   = SYM_W + CODE_W + LEN_W + BYTE_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = BYTE_W;

    // bit accumulator: pending bits plus two codes
    localparam int ACC_W        = BYTE_W + 2 * MAX_CODE_LEN;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int USED_W       = $clog2(BYTE_W + 1);
    localparam int BYTE_SHIFT   = $clog2(BYTE_W);
    localparam int OUT_MAX      = (ACC_W - 1) / BYTE_W;
    localparam int OCNT_W       = $clog2(OUT_MAX + 1);

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } tbl_entry_t;

    // registered input item with its two table lookups
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        tbl_entry_t        ent_hi;
        tbl_entry_t        ent_lo;
    } s1_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_beat_t;

    // result bytes produced by one item
    typedef struct packed {
        logic [OCNT_W-1:0]              cnt;
        out_beat_t [OUT_MAX-1:0]        beats;
    } out_group_t;

endpackage

@@ rtl/nibble_huffman_encoder_packer_top.sv @@
// top level of the nibble huffman encoder and bit packer
// depends on nhe_pkg, nhe_code_table, nhe_packer, nhe_out_buffer
`timescale 1ns / 1ps

// usage
//   input stream (s_): one transaction per command; s_tuser carries the command
//   (load table entry, encode byte, flush). loads write the 16-entry code table,
//   encodes append the codes of the high then the low nibble msb first, a flush
//   emits the left-aligned pending bits and then the padding count with m_tlast
//   output stream (m_): one packed byte per transaction, m_tlast only on the
//   padding-count byte of a flush
//   a command is registered together with its table lookups, then packed and
//   loaded into the result register once that has room; its first byte is then
//   driven on m_tdata from the result register
//   one command per cycle while each yields at most one byte and m_tready is high;
//   a command with n bytes holds the result register until its last byte is taken,
//   up to 4 bytes per encode (two 15-bit codes) and 2 per flush, one per transfer
//   a load takes effect for an encode accepted in the very next cycle
//   reset: code table reads as all zero-length codes, nothing pending, no output
//   receiver stall: the result register holds its byte, one more command waits in
//   the input register, then s_tready drops

module nibble_huffman_encoder_packer_top import nhe_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // symbol[3:0], code_bits[18:4],
                                           // code_len[22:19], data_byte[30:23], zero pad
    input  logic [FUNC_W-1:0]    s_tuser,  // func[1:0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_byte[7:0]
    output logic                 m_tlast
);

    localparam int SYM_LSB  = 0;
    localparam int CODE_LSB = SYM_LSB + SYM_W;
    localparam int LEN_LSB  = CODE_LSB + CODE_W;
    localparam int BYTE_LSB = LEN_LSB + LEN_W;

    s1_item_t   item;
    out_group_t group;
    logic       advance;
    logic       room;
    logic       accept;

    // input register frees up whenever its command moves into the result register
    assign s_tready = !item.valid || advance;
    assign accept   = s_tvalid && s_tready;

    nhe_code_table u_code_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .func      (s_tuser),
        .symbol    (s_tdata[CODE_LSB-1:SYM_LSB]),
        .code_bits (s_tdata[LEN_LSB-1:CODE_LSB]),
        .code_len  (s_tdata[BYTE_LSB-1:LEN_LSB]),
        .data_byte (s_tdata[BYTE_LSB+BYTE_W-1:BYTE_LSB]),
        .advance   (advance),
        .item      (item)
    );

    // packing of both nibbles against the pending byte
    nhe_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .room    (room),
        .advance (advance),
        .group   (group)
    );

    // result register, drained one byte per transaction
    nhe_out_buffer u_out_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .group    (group),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/nhe_code_table.sv @@
// input register stage and 16-entry code table memory with two registered read ports
// depends on nhe_pkg
`timescale 1ns / 1ps

module nhe_code_table import nhe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [FUNC_W-1:0] func,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_len,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              advance,
    output s1_item_t          item
);

    tbl_entry_t             tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tbl_vld_reg;

    tbl_entry_t        wr_entry;
    logic [LEN_W-1:0]  wr_len;
    logic [SYM_W-1:0]  rd_hi_addr;
    logic [SYM_W-1:0]  rd_lo_addr;

    tbl_entry_t        hi_raw_reg;
    tbl_entry_t        lo_raw_reg;
    logic              hi_ok_reg;
    logic              lo_ok_reg;
    logic [FUNC_W-1:0] func_reg;
    logic              valid_reg;

    logic              tbl_wr;

    assign tbl_wr     = accept && (func == FUNC_LOAD);
    assign rd_hi_addr = data_byte[BYTE_W-1 -: SYM_W];
    assign rd_lo_addr = data_byte[SYM_W-1:0];

    // clamp length, clear code bits above it
    always_comb begin
        wr_len = (code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_len;
        wr_entry.len  = wr_len;
        wr_entry.code = code_bits & ~({CODE_W{1'b1}} << wr_len);
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            tbl_mem[symbol] <= wr_entry;
        end
    end

    // never-written entries read as zero-length codes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_vld_reg <= '0;
        end else if (tbl_wr) begin
            tbl_vld_reg[symbol] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hi_raw_reg <= tbl_mem[rd_hi_addr];
            lo_raw_reg <= tbl_mem[rd_lo_addr];
            hi_ok_reg  <= tbl_vld_reg[rd_hi_addr];
            lo_ok_reg  <= tbl_vld_reg[rd_lo_addr];
            func_reg   <= func;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (accept) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_comb begin
        item.valid  = valid_reg;
        item.func   = func_reg;
        item.ent_hi = hi_ok_reg ? hi_raw_reg : '0;
        item.ent_lo = lo_ok_reg ? lo_raw_reg : '0;
    end

endmodule

@@ rtl/nhe_packer.sv @@
// bit packer: appends both codes to the pending bits and splits off full bytes
// depends on nhe_pkg
`timescale 1ns / 1ps

module nhe_packer import nhe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  s1_item_t   item,
    input  logic       room,
    output logic       advance,
    output out_group_t group
);

    logic [BYTE_W-1:0] pend_reg;
    logic [BYTE_W-1:0] pend_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;

    acc_t              acc_one;
    acc_t              acc_two;
    acc_t              aligned;
    logic [TOT_W-1:0]  tot;
    logic [OCNT_W-1:0] n_bytes;
    logic [TOT_W-1:0]  rem;
    logic [USED_W-1:0] free;

    assign advance = item.valid && room;

    // concatenated bit stream, right aligned
    always_comb begin
        acc_one = (acc_t'(pend_reg) << item.ent_hi.len) | acc_t'(item.ent_hi.code);
        acc_two = (acc_one << item.ent_lo.len) | acc_t'(item.ent_lo.code);
        tot     = TOT_W'(used_reg) + TOT_W'(item.ent_hi.len) + TOT_W'(item.ent_lo.len);
        // an exactly full byte stays pending
        n_bytes = (tot > TOT_W'(BYTE_W)) ? OCNT_W'((tot - TOT_W'(1)) >> BYTE_SHIFT) : '0;
        rem     = tot - (TOT_W'(n_bytes) << BYTE_SHIFT);
        aligned = acc_two << (TOT_W'(ACC_W) - tot);
        free    = USED_W'(BYTE_W) - used_reg;
    end

    always_comb begin
        pend_next = pend_reg;
        used_next = used_reg;
        group.cnt = '0;
        for (int i = 0; i < OUT_MAX; i++) begin
            group.beats[i].data = aligned[ACC_W-1-BYTE_W*i -: BYTE_W];
            group.beats[i].last = 1'b0;
        end
        unique case (item.func)
            FUNC_ENCODE: begin
                group.cnt = n_bytes;
                pend_next = acc_two[BYTE_W-1:0] & ~({BYTE_W{1'b1}} << rem);
                used_next = USED_W'(rem);
            end
            FUNC_FLUSH: begin
                // left-aligned remainder, then the padding count
                group.cnt           = OCNT_W'(2);
                group.beats[0].data = BYTE_W'(pend_reg << free);
                group.beats[1].data = BYTE_W'(free);
                group.beats[1].last = 1'b1;
                pend_next           = '0;
                used_next           = '0;
            end
            default: begin
                // table loads and the unused code leave the packer as is
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            used_reg <= '0;
        end else if (advance) begin
            pend_reg <= pend_next;
            used_reg <= used_next;
        end
    end

endmodule

@@ rtl/nhe_out_buffer.sv @@
// result register: holds one item's bytes and hands out one per ready cycle
// depends on nhe_pkg
`timescale 1ns / 1ps

module nhe_out_buffer import nhe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  out_group_t        group,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic              m_tlast
);

    out_beat_t         buf_reg [OUT_MAX];
    logic [OCNT_W-1:0] cnt_reg;
    logic              take;

    assign m_tvalid = (cnt_reg != '0);
    assign take     = m_tvalid && m_tready;
    assign room     = (cnt_reg == '0) || ((cnt_reg == OCNT_W'(1)) && m_tready);
    assign m_tdata  = M_TDATA_W'(buf_reg[0].data);
    assign m_tlast  = buf_reg[0].last;

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < OUT_MAX; i++) begin
                buf_reg[i] <= group.beats[i];
            end
        end else if (take) begin
            for (int i = 0; i < OUT_MAX - 1; i++) begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= group.cnt;
        end else if (take) begin
            cnt_reg <= cnt_reg - OCNT_W'(1);
        end
    end

endmodule

@@ rtl/nhe_checker.sv @@
// port-level checks for the nibble huffman encoder top level, bound to it
// depends on nhe_pkg and nibble_huffman_encoder_packer_top
`timescale 1ns / 1ps

module nhe_checker import nhe_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // padding count never exceeds eight (zero when the pending byte was full)
    a_last_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata <= M_TDATA_W'(BYTE_W)))
        else $error("padding count out of range");

    // with the result register empty the input side never stalls
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // reset leaves no result and an open input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the datapath");

endmodule

bind nibble_huffman_encoder_packer_top nhe_checker u_nhe_checker (.*);
